/* hw/rtl/apg_pkg.sv */
// ----------------------------------------------------------------------------
// apg_pkg: shared types and constants of the arc point generator
// Item tag, configuration register indexes, fixed-point constants, atan table.
// ----------------------------------------------------------------------------
package apg_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    RegCenterX      = 3'd0,
    RegCenterY      = 3'd1,
    RegRadius       = 3'd2,
    RegStartAngle   = 3'd3,
    RegEndAngle     = 3'd4,
    RegSegmentCount = 3'd5,
    RegFullCircle   = 3'd6
  } cfg_reg_e;

  // side information that travels with every item down the pipeline
  typedef struct packed {
    logic               valid;
    logic               is_last;
    logic               index_error;
    logic               neg;
    logic signed [31:0] start;
  } tag_t;

  localparam int unsigned DivQuoW  = 34;  // quotient bits of the angle step
  localparam int unsigned RedSteps = 18;  // subtract steps of the range reduction
  localparam int unsigned CordicW  = 34;  // x, y, z datapath width

  localparam logic signed [32:0] FullSweepQ16 = 33'sd411775;
  localparam logic [52:0]        TwoPiQ32     = 53'd26986075409;
  localparam logic [34:0]        HalfPiQ32    = 35'd6746518852;
  localparam logic [34:0]        PiQ32        = 35'd13493037704;
  localparam logic [34:0]        ThreeHalfPiQ32 = 35'd20239556556;
  localparam logic signed [33:0] CordicGainQ30  = 34'sd652032874;

  // arctangent of 2^-i in Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd843314857;
      5'd1:  a = 32'd497837829;
      5'd2:  a = 32'd263043837;
      5'd3:  a = 32'd133525159;
      5'd4:  a = 32'd67021687;
      5'd5:  a = 32'd33543516;
      5'd6:  a = 32'd16775851;
      5'd7:  a = 32'd8388437;
      5'd8:  a = 32'd4194283;
      5'd9:  a = 32'd2097149;
      5'd10: a = 32'd1048576;
      5'd11: a = 32'd524288;
      5'd12: a = 32'd262144;
      5'd13: a = 32'd131072;
      5'd14: a = 32'd65536;
      5'd15: a = 32'd32768;
      5'd16: a = 32'd16384;
      5'd17: a = 32'd8192;
      5'd18: a = 32'd4096;
      5'd19: a = 32'd2048;
      5'd20: a = 32'd1024;
      5'd21: a = 32'd512;
      5'd22: a = 32'd256;
      5'd23: a = 32'd128;
      5'd24: a = 32'd64;
      5'd25: a = 32'd32;
      5'd26: a = 32'd16;
      5'd27: a = 32'd8;
      5'd28: a = 32'd4;
      5'd29: a = 32'd2;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/apg_div.sv */
// ----------------------------------------------------------------------------
// apg_div: pipelined restoring divider for the angle step
// One quotient bit per stage, rounded to nearest by adding half the divisor.
// ----------------------------------------------------------------------------
module apg_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  apg_pkg::tag_t tag_i,
  input  logic [47:0]   mag_i,
  input  logic [15:0]   divisor_i,
  output apg_pkg::tag_t tag_o,
  output logic [apg_pkg::DivQuoW-1:0] quo_o
);
  import apg_pkg::*;

  localparam int unsigned QW = DivQuoW;

  function automatic logic [16:0] div_step(input logic [15:0] rem, input logic b,
                                           input logic [15:0] d);
    logic [16:0] t;
    logic        qb;
    t  = {rem, b};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    return {t[15:0], qb};
  endfunction

  logic [48:0]   dividend;
  logic [16:0]   step_r [QW];
  logic [15:0]   rem_d  [QW];
  logic [15:0]   rem_q  [QW];
  logic [QW-1:0] work_d [QW];
  logic [QW-1:0] work_q [QW];
  tag_t          tag_q  [QW];

  assign dividend = {1'b0, mag_i} + 49'(divisor_i >> 1);

  // work register shifts dividend bits out the top and quotient bits in the bottom
  always_comb begin
    step_r[0] = div_step({1'b0, dividend[48:QW]}, dividend[QW-1], divisor_i);
    rem_d[0]  = step_r[0][16:1];
    work_d[0] = {dividend[QW-2:0], step_r[0][0]};
    for (int j = 1; j < QW; j++) begin
      step_r[j] = div_step(rem_q[j-1], work_q[j-1][QW-1], divisor_i);
      rem_d[j]  = step_r[j][16:1];
      work_d[j] = {work_q[j-1][QW-2:0], step_r[j][0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < QW; j++) begin
        tag_q[j] <= '0;
      end
    end else if (en_i) begin
      tag_q[0] <= tag_i;
      for (int j = 1; j < QW; j++) begin
        tag_q[j] <= tag_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j]  <= rem_d[j];
        work_q[j] <= work_d[j];
      end
    end
  end

  assign tag_o = tag_q[QW-1];
  assign quo_o = work_q[QW-1];

endmodule

/* hw/rtl/apg_cordic.sv */
// ----------------------------------------------------------------------------
// apg_cordic: pipelined sine and cosine of a Q16.16 angle
// Range reduction by 2*pi, quadrant split, rotation-mode CORDIC stages.
// ----------------------------------------------------------------------------
module apg_cordic #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  apg_pkg::tag_t      tag_i,
  input  logic signed [35:0] theta_i,
  output apg_pkg::tag_t      tag_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import apg_pkg::*;

  localparam int unsigned NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int unsigned RS = RedSteps;
  localparam int unsigned CW = CordicW;

  // range reduction: offset by a multiple of 2*pi, then binary subtract steps
  logic [52:0] red_in;
  logic [52:0] red_d [RS];
  logic [52:0] red_q [RS];
  tag_t        rtag_q [RS];

  assign red_in = {theta_i[35], theta_i, 16'h0000} + (TwoPiQ32 << (RS - 1));

  always_comb begin
    red_d[0] = (red_in >= (TwoPiQ32 << (RS - 1))) ? red_in - (TwoPiQ32 << (RS - 1))
                                                   : red_in;
    for (int j = 1; j < RS; j++) begin
      red_d[j] = (red_q[j-1] >= (TwoPiQ32 << (RS - 1 - j)))
                 ? red_q[j-1] - (TwoPiQ32 << (RS - 1 - j)) : red_q[j-1];
    end
  end

  // quadrant and residual angle in Q2.30
  logic [34:0] red_r;
  logic [1:0]  quad_d;
  logic [34:0] resid;
  logic [33:0] resid_rnd;
  logic [1:0]  quad_q;
  logic [31:0] z0_q;
  tag_t        qtag_q;

  assign red_r = red_q[RS-1][34:0];

  always_comb begin
    if (red_r >= ThreeHalfPiQ32) begin
      quad_d = 2'd3;
      resid  = red_r - ThreeHalfPiQ32;
    end else if (red_r >= PiQ32) begin
      quad_d = 2'd2;
      resid  = red_r - PiQ32;
    end else if (red_r >= HalfPiQ32) begin
      quad_d = 2'd1;
      resid  = red_r - HalfPiQ32;
    end else begin
      quad_d = 2'd0;
      resid  = red_r;
    end
    resid_rnd = resid[33:0] + 34'd2;
  end

  // rotation stages
  logic signed [CW-1:0] x_d [NS];
  logic signed [CW-1:0] y_d [NS];
  logic signed [CW-1:0] z_d [NS];
  logic signed [CW-1:0] x_q [NS];
  logic signed [CW-1:0] y_q [NS];
  logic signed [CW-1:0] z_q [NS];
  logic [1:0]           cq_q [NS];
  tag_t                 ctag_q [NS];
  logic signed [CW-1:0] z_init;

  assign z_init = {2'b00, z0_q};

  always_comb begin
    if (!z_init[CW-1]) begin
      x_d[0] = CordicGainQ30;
      y_d[0] = CordicGainQ30;
      z_d[0] = z_init - $signed({2'b00, atan_q30(5'd0)});
    end else begin
      x_d[0] = CordicGainQ30;
      y_d[0] = -CordicGainQ30;
      z_d[0] = z_init + $signed({2'b00, atan_q30(5'd0)});
    end
    for (int j = 1; j < NS; j++) begin
      if (!z_q[j-1][CW-1]) begin
        x_d[j] = x_q[j-1] - (y_q[j-1] >>> j);
        y_d[j] = y_q[j-1] + (x_q[j-1] >>> j);
        z_d[j] = z_q[j-1] - $signed({2'b00, atan_q30(5'(j))});
      end else begin
        x_d[j] = x_q[j-1] + (y_q[j-1] >>> j);
        y_d[j] = y_q[j-1] - (x_q[j-1] >>> j);
        z_d[j] = z_q[j-1] + $signed({2'b00, atan_q30(5'(j))});
      end
    end
  end

  // quadrant map back to the full circle
  logic signed [CW-1:0] cos_d;
  logic signed [CW-1:0] sin_d;
  logic signed [31:0]   cos_q;
  logic signed [31:0]   sin_q;
  tag_t                 otag_q;

  always_comb begin
    case (cq_q[NS-1])
      2'd0: begin
        cos_d = x_q[NS-1];
        sin_d = y_q[NS-1];
      end
      2'd1: begin
        cos_d = -y_q[NS-1];
        sin_d = x_q[NS-1];
      end
      2'd2: begin
        cos_d = -x_q[NS-1];
        sin_d = -y_q[NS-1];
      end
      default: begin
        cos_d = y_q[NS-1];
        sin_d = -x_q[NS-1];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < RS; j++) begin
        rtag_q[j] <= '0;
      end
      qtag_q <= '0;
      for (int j = 0; j < NS; j++) begin
        ctag_q[j] <= '0;
      end
      otag_q <= '0;
    end else if (en_i) begin
      rtag_q[0] <= tag_i;
      for (int j = 1; j < RS; j++) begin
        rtag_q[j] <= rtag_q[j-1];
      end
      qtag_q    <= rtag_q[RS-1];
      ctag_q[0] <= qtag_q;
      for (int j = 1; j < NS; j++) begin
        ctag_q[j] <= ctag_q[j-1];
      end
      otag_q <= ctag_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < RS; j++) begin
        red_q[j] <= red_d[j];
      end
      quad_q <= quad_d;
      z0_q   <= resid_rnd[33:2];
      for (int j = 0; j < NS; j++) begin
        x_q[j] <= x_d[j];
        y_q[j] <= y_d[j];
        z_q[j] <= z_d[j];
      end
      cq_q[0] <= quad_q;
      for (int j = 1; j < NS; j++) begin
        cq_q[j] <= cq_q[j-1];
      end
      cos_q <= cos_d[31:0];
      sin_q <= sin_d[31:0];
    end
  end

  assign tag_o = otag_q;
  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

/* hw/rtl/arc_point_generator.sv */
// ----------------------------------------------------------------------------
// arc_point_generator: vertex generator for tessellated circles and arcs
// Index in, one saturated Q16.16 vertex out, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// usage:
//   - registers must be written on the cfg channel (index, data) only while
//     no point is in flight (not enforced here); cfg_ready_o is always high
//   - s_axis carries the point index; m_axis returns x (low half) and y (high
//     half) of the vertex, tlast when the index equals the segment count and
//     tuser when the index exceeds it (coordinates are then zero)
//   - one transaction per cycle in and out while the receiver does not
//     stall; every item passes through the 34-stage angle divider, the
//     18-step range reduction and the CORDIC chain before reaching the
//     output register
//   - the whole pipeline advances together; a two-entry output buffer holds
//     results while the receiver stalls, and s_axis_tready drops only when
//     both entries are full
//   - reset empties the pipeline and the output buffer and loads the
//     register defaults: unit circle at the origin, full sweep, 16 segments
// ----------------------------------------------------------------------------
module arc_point_generator #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] point_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] point_x, [63:32] point_y
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] index_error
);
  import apg_pkg::*;

  // configuration registers
  logic signed [31:0] center_x_q, center_y_q, start_angle_q, end_angle_q;
  logic [30:0]        radius_q;
  logic [15:0]        seg_count_q;
  logic               full_circle_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      radius_q      <= 31'd65536;
      start_angle_q <= '0;
      end_angle_q   <= 32'sd411775;
      seg_count_q   <= 16'd16;
      full_circle_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegCenterX:      center_x_q    <= cfg_data_i;
        RegCenterY:      center_y_q    <= cfg_data_i;
        RegRadius:       radius_q      <= cfg_data_i[30:0];
        RegStartAngle:   start_angle_q <= cfg_data_i;
        RegEndAngle:     end_angle_q   <= cfg_data_i;
        RegSegmentCount: seg_count_q   <= cfg_data_i[15:0];
        RegFullCircle:   full_circle_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic skid_valid_q;
  logic en;
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // stage 1: sweep times index
  logic signed [32:0] sweep;
  logic signed [49:0] prod_n;
  logic [49:0]        prod_abs;
  tag_t               tag_s1_d, tag_s1_q;
  logic [47:0]        mag_q;
  logic [15:0]        divisor;

  always_comb begin
    sweep    = full_circle_q ? FullSweepQ16
                             : (33'(end_angle_q) - 33'(start_angle_q));
    prod_n   = sweep * $signed({1'b0, s_axis_tdata});
    prod_abs = prod_n[49] ? 50'(-prod_n) : 50'(prod_n);
    tag_s1_d.valid       = s_axis_tvalid;
    tag_s1_d.is_last     = (s_axis_tdata == seg_count_q);
    tag_s1_d.index_error = (s_axis_tdata > seg_count_q);
    tag_s1_d.neg         = prod_n[49];
    tag_s1_d.start       = full_circle_q ? 32'sd0 : start_angle_q;
  end

  // a zero count leaves only index zero in range, where any divisor gives zero
  assign divisor = (seg_count_q == 16'd0) ? 16'd1 : seg_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_s1_q <= '0;
    end else if (en) begin
      tag_s1_q <= tag_s1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= prod_abs[47:0];
    end
  end

  tag_t                tag_dv;
  logic [DivQuoW-1:0]  quo;

  apg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .tag_i     (tag_s1_q),
    .mag_i     (mag_q),
    .divisor_i (divisor),
    .tag_o     (tag_dv),
    .quo_o     (quo)
  );

  // angle = start +- step
  logic signed [34:0] step_s;
  logic signed [35:0] theta_d, theta_q;
  tag_t               tag_th_q;

  always_comb begin
    step_s  = tag_dv.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    theta_d = 36'(tag_dv.start) + 36'(step_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_th_q <= '0;
    end else if (en) begin
      tag_th_q <= tag_dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      theta_q <= theta_d;
    end
  end

  tag_t               tag_cs;
  logic signed [31:0] cos_v, sin_v;

  apg_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (tag_th_q),
    .theta_i (theta_q),
    .tag_o   (tag_cs),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // radius products
  logic signed [31:0] rad_s;
  logic signed [63:0] px_prod_d, py_prod_d, px_prod_q, py_prod_q;
  tag_t               tag_m_q;

  assign rad_s     = $signed({1'b0, radius_q});
  assign px_prod_d = rad_s * cos_v;
  assign py_prod_d = rad_s * sin_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_m_q <= '0;
    end else if (en) begin
      tag_m_q <= tag_cs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_prod_q <= px_prod_d;
      py_prod_q <= py_prod_d;
    end
  end

  // round, add center, saturate
  function automatic logic [31:0] place(input logic signed [63:0] p,
                                        input logic signed [31:0] c);
    logic signed [63:0] r;
    logic signed [34:0] s;
    r = p + 64'sd536870912;
    s = 35'(c) + 35'($signed(r[63:30]));
    if (s > 35'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (s < -35'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  logic [31:0] tail_x, tail_y;
  logic        deliver;

  assign tail_x  = tag_m_q.index_error ? 32'd0 : place(px_prod_q, center_x_q);
  assign tail_y  = tag_m_q.index_error ? 32'd0 : place(py_prod_q, center_y_q);
  assign deliver = en && tag_m_q.valid;

  // output register plus skid entry
  logic        out_valid_q;
  logic [63:0] out_data_q, skid_data_q;
  logic        out_last_q, skid_last_q, out_err_q, skid_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= deliver;
      end
    end else if (deliver) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        out_last_q <= skid_last_q;
        out_err_q  <= skid_err_q;
      end else begin
        out_data_q <= {tail_y, tail_x};
        out_last_q <= tag_m_q.is_last && !tag_m_q.index_error;
        out_err_q  <= tag_m_q.index_error;
      end
    end else if (deliver) begin
      skid_data_q <= {tail_y, tail_x};
      skid_last_q <= tag_m_q.is_last && !tag_m_q.index_error;
      skid_err_q  <= tag_m_q.index_error;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid entry filled without a stalled output");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_data_q == 64'd0 && !out_last_q))
    else $error("out-of-range index produced a nonzero vertex or tlast");

endmodule

/* tb/apg_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// apg_checker: vertex predictor and scoreboard for the arc point generator
// Mirrors register writes, predicts each accepted point index and compares
// every returned vertex against the oldest pending prediction.
// ----------------------------------------------------------------------------
module apg_checker #(
  parameter int unsigned CORDIC_STAGES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          vertex_count_o
);
  import apg_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
    logic               err;
  } vertex_t;

  localparam longint TwoPi  = 64'sd26986075409;
  localparam longint HalfPi = 64'sd6746518852;

  longint    ctr_x, ctr_y, rad, ang_a, ang_b;
  int        seg_cnt;
  bit        full_sweep;
  vertex_t   vertex_q[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] sat(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic vertex_t predict_vertex(int idx);
    vertex_t res;
    longint  base, sweep, prod, mag, q, r, k, z, x, y, nx, c, s;
    res = '0;
    if (idx > seg_cnt) begin
      res.err = 1'b1;
      return res;
    end
    base  = full_sweep ? 0 : ang_a;
    sweep = full_sweep ? 64'sd411775 : ang_b - ang_a;
    q = 0;
    if (idx != 0 && seg_cnt != 0) begin
      prod = sweep * idx;
      mag  = prod < 0 ? -prod : prod;
      q    = (mag + seg_cnt / 2) / seg_cnt;
      if (prod < 0) q = -q;
    end
    r = ((base + q) * 65536) % TwoPi;
    if (r < 0) r += TwoPi;
    k = r / HalfPi;
    if (k > 3) k = 3;
    z = (r - k * HalfPi + 2) >>> 2;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - fshift(y, i);
        y  = y + fshift(x, i);
        z  = z - longint'(atan_q30(i[4:0]));
      end else begin
        nx = x + fshift(y, i);
        y  = y - fshift(x, i);
        z  = z + longint'(atan_q30(i[4:0]));
      end
      x = nx;
    end
    case (k)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    res.x    = sat(ctr_x + fshift(rad * c + (64'sd1 <<< 29), 30));
    res.y    = sat(ctr_y + fshift(rad * s + (64'sd1 <<< 29), 30));
    res.last = (idx == seg_cnt);
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    vertex_t exp_v;
    if (!rst_ni) begin
      ctr_x = 0; ctr_y = 0; rad = 65536; ang_a = 0; ang_b = 411775;
      seg_cnt = 16; full_sweep = 1'b1;
      vertex_q.delete();
      fail_count_o <= 0;
      vertex_count_o <= 0;
    end else begin
      // compare the outgoing transaction before this edge's updates land
      if (m_axis_tvalid && m_axis_tready) begin
        vertex_count_o <= vertex_count_o + 1;
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_v.x || m_axis_tdata[63:32] !== exp_v.y ||
              m_axis_tlast !== exp_v.last || m_axis_tuser !== exp_v.err) begin
            fail_count_o <= fail_count_o + 1;
            if (m_axis_tdata[31:0] !== exp_v.x)
              $error("point_x expected %h got %h", exp_v.x, m_axis_tdata[31:0]);
            if (m_axis_tdata[63:32] !== exp_v.y)
              $error("point_y expected %h got %h", exp_v.y, m_axis_tdata[63:32]);
            if (m_axis_tlast !== exp_v.last)
              $error("is_last expected %b got %b", exp_v.last, m_axis_tlast);
            if (m_axis_tuser !== exp_v.err)
              $error("index_error expected %b got %b", exp_v.err, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        vertex_q.push_back(predict_vertex(int'(s_axis_tdata)));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegCenterX:      ctr_x = longint'(signed'(cfg_data_i));
          RegCenterY:      ctr_y = longint'(signed'(cfg_data_i));
          RegRadius:       rad = longint'(cfg_data_i[30:0]);
          RegStartAngle:   ang_a = longint'(signed'(cfg_data_i));
          RegEndAngle:     ang_b = longint'(signed'(cfg_data_i));
          RegSegmentCount: seg_cnt = int'(cfg_data_i[15:0]);
          RegFullCircle:   full_sweep = cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign pending_o = vertex_q.size();

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression for the arc point generator
// Directed corner points, then random arc setups and point indexes under
// several sender and receiver throttling phases, checked by apg_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import apg_pkg::*;

  localparam int Latency = 120;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast, m_axis_tuser;
  int          fail_count, pending, vertex_count;
  int          send_idle_pct, recv_stall_pct, cur_segs, wait_cnt;

  arc_point_generator u_top (.*);

  apg_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .m_axis_tuser, .fail_count_o(fail_count), .pending_o(pending),
    .vertex_count_o(vertex_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver throttling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == RegSegmentCount) cur_segs = int'(val[15:0]);
  endtask

  task automatic send_point(logic [15:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= idx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(4))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(32'h3ffff) - 32'h1ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] rand_index();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return 16'($urandom());
    if (sel == 1) return 16'hffff;
    if (sel < 4 && cur_segs < 65535) return 16'(cur_segs + 1);
    if (sel == 4) return 16'(cur_segs);
    return 16'($urandom_range(cur_segs));
  endfunction

  task automatic random_setup(int phase);
    write_reg(RegCenterX, rand_word());
    write_reg(RegCenterY, rand_word());
    case ($urandom_range(3))
      0: write_reg(RegRadius, 32'h7fffffff);
      1: write_reg(RegRadius, 32'h80000000 | $urandom_range(32'h200000));
      default: write_reg(RegRadius, $urandom());
    endcase
    write_reg(RegStartAngle, rand_word());
    write_reg(RegEndAngle, rand_word());
    if (phase % 7 == 0) write_reg(RegSegmentCount, 32'hffff);
    else if (phase % 7 == 1) write_reg(RegSegmentCount, 32'h1);
    else if (phase % 7 == 2) write_reg(RegSegmentCount, 32'hffff0000);
    else write_reg(RegSegmentCount, $urandom_range(64) | ($urandom() & 32'hffff0000));
    write_reg(RegFullCircle, $urandom());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    send_idle_pct = 0; recv_stall_pct = 0; cur_segs = 16;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: full unit circle, then out of range indexes
    for (int i = 0; i <= 17; i++) send_point(16'(i));
    send_point(16'hffff);
    drain();
    // arc with extreme angles and center, saturating radius
    write_reg(RegCenterX, 32'h7fffffff);
    write_reg(RegCenterY, 32'h80000000);
    write_reg(RegRadius, 32'hffffffff);
    write_reg(RegStartAngle, 32'h80000000);
    write_reg(RegEndAngle, 32'h7fffffff);
    write_reg(RegSegmentCount, 32'h0000_0003);
    write_reg(RegFullCircle, 32'h0000_0000);
    for (int i = 0; i <= 4; i++) send_point(16'(i));
    drain();

    for (int phase = 0; phase < 28; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      random_setup(phase);
      for (int n = 0; n < 58; n++) send_point(rand_index());
      drain();
    end

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    $display("covered %0d vertices over 30 arc setups with four throttling mixes",
             vertex_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
